// File: design/crcw_pkg.sv
// Shared types, constants and a table-building function for the wide CRC-32 stream unit.
package crcw_pkg;

    // Reflected IEEE 802.3 polynomial and the remainder's reset value
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // Byte count field width, and depth of the queue between front and back
    localparam int CNT_W   = 5;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One classified chunk: data contribution plus control for the back end
    typedef struct packed {
        logic [31:0]      data_crc;
        logic [CNT_W-1:0] cnt;
        logic             first;
        logic             last;
        logic [31:0]      seed;
    } t_chunk;

    // Advance a remainder through a run of zero message bits.
    // Called only with constant arguments, to build the XOR-matrix tables.
    function automatic logic [31:0] crcw_zero_shift(input logic [31:0] rem_in,
                                                    input int unsigned nbits);
        logic [31:0] rem;
        rem = rem_in;
        for (int unsigned k = 0; k < nbits; k++) begin
            rem = rem[0] ? ((rem >> 1) ^ CRC_POLY) : (rem >> 1);
        end
        return rem;
    endfunction

endpackage

// File: design/crcw_front.sv
// Front end: accept chunks, trim valid bytes and move them to the top, compute their CRC contribution.
module crcw_front #(
    parameter int CHUNK_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [63:0]           i_data_low,
    input  logic [63:0]           i_data_high,
    input  logic [4:0]            i_valid_bytes,
    input  logic                  i_first_chunk,
    input  logic                  i_last_chunk,
    input  logic [31:0]           i_seed,
    input  logic                  i_q_full,
    output logic                  o_push,
    output crcw_pkg::t_chunk      o_push_data
);
    import crcw_pkg::*;

    localparam int CHUNK_BITS = 8 * CHUNK_BYTES;

    logic [127:0]           w_wide;
    logic [CHUNK_BITS-1:0]  w_chunk;
    logic [CHUNK_BITS-1:0]  w_masked;
    logic [CHUNK_BITS-1:0]  w_aligned;
    logic [CNT_W-1:0]       w_cnt;
    logic [CNT_W-1:0]       w_pad;
    logic                   w_accept;
    logic [31:0]            w_dcol [CHUNK_BITS];
    logic [31:0]            w_dcrc;

    logic                   r_valid;
    logic                   n_valid;
    logic [CHUNK_BITS-1:0]  r_aligned;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_first;
    logic                   r_last;
    logic [31:0]            r_seed;

    // Saturate the byte count to the chunk size
    assign w_wide  = {i_data_high, i_data_low};
    assign w_chunk = w_wide[CHUNK_BITS-1:0];
    assign w_cnt   = (i_valid_bytes > CNT_W'(CHUNK_BYTES)) ? CNT_W'(CHUNK_BYTES) : i_valid_bytes;
    assign w_pad   = CNT_W'(CHUNK_BYTES) - w_cnt;

    // Drop bytes past the count, then move valid bytes to the top so that
    // the zero bytes ahead of them leave a zero-seeded CRC unchanged
    always_comb begin
        w_masked = '0;
        for (int b = 0; b < CHUNK_BYTES; b++) begin
            if (CNT_W'(b) < w_cnt) begin
                w_masked[b*8 +: 8] = w_chunk[b*8 +: 8];
            end
        end
        w_aligned = w_masked << {w_pad, 3'b000};
    end

    // Hold the stage while the queue is full
    assign o_in_stall = r_valid && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign n_valid    = w_accept || (r_valid && i_q_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_aligned <= w_aligned;
            r_cnt     <= w_cnt;
            r_first   <= i_first_chunk;
            r_last    <= i_last_chunk;
            r_seed    <= i_seed;
        end
    end

    // Column of the data matrix: one message bit through the rest of the chunk
    for (genvar gp = 0; gp < CHUNK_BITS; gp++) begin : g_dcol
        assign w_dcol[gp] = crcw_zero_shift(CRC_POLY, CHUNK_BITS - 1 - gp);
    end

    // XOR tree over the aligned chunk
    always_comb begin
        w_dcrc = '0;
        for (int p = 0; p < CHUNK_BITS; p++) begin
            if (r_aligned[p]) begin
                w_dcrc = w_dcrc ^ w_dcol[p];
            end
        end
    end

    assign o_push               = r_valid && !i_q_full;
    assign o_push_data.data_crc = w_dcrc;
    assign o_push_data.cnt      = r_cnt;
    assign o_push_data.first    = r_first;
    assign o_push_data.last     = r_last;
    assign o_push_data.seed     = r_seed;

endmodule

// File: design/crcw_queue.sv
// Short FIFO of classified chunks between the front and back ends.
module crcw_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  crcw_pkg::t_chunk i_push_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output crcw_pkg::t_chunk o_head
);
    import crcw_pkg::*;

    t_chunk               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_CNT_W-1:0]   n_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// File: design/crcw_back.sv
// Back end: fold chunk contributions into the running remainder and deliver final CRCs.
module crcw_back #(
    parameter int CHUNK_BYTES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  crcw_pkg::t_chunk i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [31:0]      o_crc_value
);
    import crcw_pkg::*;

    localparam int IDX_W = $clog2(CHUNK_BYTES + 1);

    logic [31:0]      w_acol [CHUNK_BYTES+1][32];
    logic [IDX_W-1:0] w_idx;
    logic [31:0]      w_base;
    logic [31:0]      w_adv;
    logic [31:0]      w_next;
    logic             w_out_free;

    logic [31:0]      r_rem;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [31:0]      r_crc;

    // Shift matrix columns: one remainder bit pushed through n zero bytes
    for (genvar gn = 0; gn <= CHUNK_BYTES; gn++) begin : g_arow
        for (genvar gj = 0; gj < 32; gj++) begin : g_acol
            assign w_acol[gn][gj] = crcw_zero_shift(32'(1) << gj, 8 * gn);
        end
    end

    // Start from the inverted seed on a first chunk
    assign w_idx  = i_head.cnt[IDX_W-1:0];
    assign w_base = i_head.first ? ~i_head.seed : r_rem;

    always_comb begin
        w_adv = '0;
        for (int j = 0; j < 32; j++) begin
            if (w_base[j]) begin
                w_adv = w_adv ^ w_acol[w_idx][j];
            end
        end
    end

    assign w_next = w_adv ^ i_head.data_crc;

    // Pop freely unless a final CRC has nowhere to go
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_pop       = i_q_valid && (!i_head.last || w_out_free);
    assign n_out_valid = (o_pop && i_head.last) || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= CRC_ONES;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_rem <= i_head.last ? CRC_ONES : w_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_crc <= ~w_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_crc;

endmodule

// File: design/crc32_wide_stream_unit.sv
// Top level of the wide CRC-32 stream unit: front end, chunk queue, back end.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------------
//   in      | input     | i_in_valid / o_in_stall   | data_low/high, valid_bytes, first,
//           |           |                           | last_chunk, seed
//   out     | output    | o_out_valid / i_out_stall | crc_value
//
// One chunk per cycle sustained while the queue has room and the output is not stalled on a
// last chunk; the back end closes the remainder loop through a shift-matrix XOR selected by the byte count.
// A final CRC is offered once its last chunk has passed the input register, the queue and
// the output register, and can be taken at the next edge.
// Synchronous active-low reset empties every stage and sets the remainder to all ones.
// A stalled output holds the back end on last chunks only; the four-entry queue
// fills before the input stalls.
module crc32_wide_stream_unit #(
    parameter int CHUNK_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_data_low,
    input  logic [63:0] i_data_high,
    input  logic [4:0]  i_valid_bytes,
    input  logic        i_first_chunk,
    input  logic        i_last_chunk,
    input  logic [31:0] i_seed,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_crc_value
);
    import crcw_pkg::*;

    logic   w_push;
    logic   w_full;
    logic   w_q_valid;
    logic   w_pop;
    t_chunk w_push_data;
    t_chunk w_head;

    crcw_front #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_low    (i_data_low),
        .i_data_high   (i_data_high),
        .i_valid_bytes (i_valid_bytes),
        .i_first_chunk (i_first_chunk),
        .i_last_chunk  (i_last_chunk),
        .i_seed        (i_seed),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_push_data   (w_push_data)
    );

    crcw_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .o_valid     (w_q_valid),
        .i_pop       (w_pop),
        .o_head      (w_head)
    );

    crcw_back #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_crc_value (o_crc_value)
    );

endmodule

// File: design/crcw_checker.sv
// Port-level checks for the wide CRC-32 stream unit, bound to the top level.
module crcw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_crc_value
);

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output request valid right after reset");

    // Reset empties the input stage, so the input is not stalled
    a_rst_stall: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled output request dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_crc_value))
        else $error("stalled output request changed");

endmodule

bind crc32_wide_stream_unit crcw_checker u_crcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_crc_value (o_crc_value)
);
